>>> rtl/sha512_stream_hash_defines.svh
// Assertion macros for the SHA-512 stream hash
`ifndef SHA512_STREAM_HASH_DEFINES_SVH
`define SHA512_STREAM_HASH_DEFINES_SVH

`define SHA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sha512 check failed");

`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sha512 check failed");

`endif

>>> rtl/sha512_pkg.sv
package sha512_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ROUND,
        S_FOLD,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic       wr_byte;
        logic [7:0] wr_data;
        logic       add_total;
        logic       start_blk;
        logic       round;
        logic       fold;
        logic       clear;
    } t_cmd;

    typedef struct packed {
        logic [6:0] fill;
        logic [6:0] round_cnt;
        logic       round_last;
    } t_status;

    localparam logic [63:0] IV [8] = '{
        64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B,
        64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
        64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
        64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
    };

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [6:0] PAD_LIMIT = 7'd112;

    function automatic logic [63:0] round_k(input logic [6:0] t);
        logic [63:0] k;
        case (t)
            7'd0: k = 64'h428A2F98D728AE22; 7'd1: k = 64'h7137449123EF65CD;
            7'd2: k = 64'hB5C0FBCFEC4D3B2F; 7'd3: k = 64'hE9B5DBA58189DBBC;
            7'd4: k = 64'h3956C25BF348B538; 7'd5: k = 64'h59F111F1B605D019;
            7'd6: k = 64'h923F82A4AF194F9B; 7'd7: k = 64'hAB1C5ED5DA6D8118;
            7'd8: k = 64'hD807AA98A3030242; 7'd9: k = 64'h12835B0145706FBE;
            7'd10: k = 64'h243185BE4EE4B28C; 7'd11: k = 64'h550C7DC3D5FFB4E2;
            7'd12: k = 64'h72BE5D74F27B896F; 7'd13: k = 64'h80DEB1FE3B1696B1;
            7'd14: k = 64'h9BDC06A725C71235; 7'd15: k = 64'hC19BF174CF692694;
            7'd16: k = 64'hE49B69C19EF14AD2; 7'd17: k = 64'hEFBE4786384F25E3;
            7'd18: k = 64'h0FC19DC68B8CD5B5; 7'd19: k = 64'h240CA1CC77AC9C65;
            7'd20: k = 64'h2DE92C6F592B0275; 7'd21: k = 64'h4A7484AA6EA6E483;
            7'd22: k = 64'h5CB0A9DCBD41FBD4; 7'd23: k = 64'h76F988DA831153B5;
            7'd24: k = 64'h983E5152EE66DFAB; 7'd25: k = 64'hA831C66D2DB43210;
            7'd26: k = 64'hB00327C898FB213F; 7'd27: k = 64'hBF597FC7BEEF0EE4;
            7'd28: k = 64'hC6E00BF33DA88FC2; 7'd29: k = 64'hD5A79147930AA725;
            7'd30: k = 64'h06CA6351E003826F; 7'd31: k = 64'h142929670A0E6E70;
            7'd32: k = 64'h27B70A8546D22FFC; 7'd33: k = 64'h2E1B21385C26C926;
            7'd34: k = 64'h4D2C6DFC5AC42AED; 7'd35: k = 64'h53380D139D95B3DF;
            7'd36: k = 64'h650A73548BAF63DE; 7'd37: k = 64'h766A0ABB3C77B2A8;
            7'd38: k = 64'h81C2C92E47EDAEE6; 7'd39: k = 64'h92722C851482353B;
            7'd40: k = 64'hA2BFE8A14CF10364; 7'd41: k = 64'hA81A664BBC423001;
            7'd42: k = 64'hC24B8B70D0F89791; 7'd43: k = 64'hC76C51A30654BE30;
            7'd44: k = 64'hD192E819D6EF5218; 7'd45: k = 64'hD69906245565A910;
            7'd46: k = 64'hF40E35855771202A; 7'd47: k = 64'h106AA07032BBD1B8;
            7'd48: k = 64'h19A4C116B8D2D0C8; 7'd49: k = 64'h1E376C085141AB53;
            7'd50: k = 64'h2748774CDF8EEB99; 7'd51: k = 64'h34B0BCB5E19B48A8;
            7'd52: k = 64'h391C0CB3C5C95A63; 7'd53: k = 64'h4ED8AA4AE3418ACB;
            7'd54: k = 64'h5B9CCA4F7763E373; 7'd55: k = 64'h682E6FF3D6B2B8A3;
            7'd56: k = 64'h748F82EE5DEFB2FC; 7'd57: k = 64'h78A5636F43172F60;
            7'd58: k = 64'h84C87814A1F0AB72; 7'd59: k = 64'h8CC702081A6439EC;
            7'd60: k = 64'h90BEFFFA23631E28; 7'd61: k = 64'hA4506CEBDE82BDE9;
            7'd62: k = 64'hBEF9A3F7B2C67915; 7'd63: k = 64'hC67178F2E372532B;
            7'd64: k = 64'hCA273ECEEA26619C; 7'd65: k = 64'hD186B8C721C0C207;
            7'd66: k = 64'hEADA7DD6CDE0EB1E; 7'd67: k = 64'hF57D4F7FEE6ED178;
            7'd68: k = 64'h06F067AA72176FBA; 7'd69: k = 64'h0A637DC5A2C898A6;
            7'd70: k = 64'h113F9804BEF90DAE; 7'd71: k = 64'h1B710B35131C471B;
            7'd72: k = 64'h28DB77F523047D84; 7'd73: k = 64'h32CAAB7B40C72493;
            7'd74: k = 64'h3C9EBE0A15C9BEBC; 7'd75: k = 64'h431D67C49C100D4C;
            7'd76: k = 64'h4CC5D4BECB3E42B6; 7'd77: k = 64'h597F299CFC657E2A;
            7'd78: k = 64'h5FCB6FAB3AD6FAEC; 7'd79: k = 64'h6C44198C4A475817;
            default: k = 64'h0;
        endcase
        return k;
    endfunction

endpackage

>>> rtl/sha512_if.sv
interface sha512_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       finish;
    modport source (output valid, data_byte, byte_valid, finish, input ready);
    modport sink   (input valid, data_byte, byte_valid, finish, output ready);
endinterface

interface sha512_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

>>> rtl/sha512_datapath.sv
module sha512_datapath
    import sha512_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [2:0]  i_word_sel,
    output t_status     o_status,
    output logic [63:0] o_total_bits,
    output logic [63:0] o_chain_word
);
    // block buffer as 16 big-endian words, doubling as the message schedule window
    logic [63:0] r_w [16];
    logic [63:0] r_h [8];
    logic [63:0] r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_hh;
    logic [6:0]  r_fill;
    logic [6:0]  r_rnd;
    logic [63:0] r_total;

    logic [63:0] s0, s1, w_new, x1, x2, ch, maj, sig0, sig1;

    always_comb begin
        s0    = {r_w[1][0], r_w[1][63:1]} ^ {r_w[1][7:0], r_w[1][63:8]} ^ (r_w[1] >> 7);
        s1    = {r_w[14][18:0], r_w[14][63:19]} ^ {r_w[14][60:0], r_w[14][63:61]}
              ^ (r_w[14] >> 6);
        w_new = r_w[0] + s0 + r_w[9] + s1;
        sig1  = {r_e[13:0], r_e[63:14]} ^ {r_e[17:0], r_e[63:18]} ^ {r_e[40:0], r_e[63:41]};
        ch    = (r_e & r_f) ^ (~r_e & r_g);
        x1    = r_hh + sig1 + ch + round_k(r_rnd) + r_w[0];
        sig0  = {r_a[27:0], r_a[63:28]} ^ {r_a[33:0], r_a[63:34]} ^ {r_a[38:0], r_a[63:39]};
        maj   = (r_a & r_b) ^ (r_a & r_c) ^ (r_b & r_c);
        x2    = sig0 + maj;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_fill  <= '0;
            r_total <= '0;
            r_rnd   <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= IV[i];
        end else begin
            if (i_cmd.add_total) r_total <= r_total + 64'd1;
            if (i_cmd.wr_byte) begin
                r_w[r_fill[6:3]] <= {r_w[r_fill[6:3]][55:0], i_cmd.wr_data};
                r_fill <= r_fill + 7'd1;
            end
            if (i_cmd.start_blk) begin
                r_rnd <= '0;
                r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2]; r_d <= r_h[3];
                r_e <= r_h[4]; r_f <= r_h[5]; r_g <= r_h[6]; r_hh <= r_h[7];
            end
            if (i_cmd.round) begin
                r_rnd <= r_rnd + 7'd1;
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                r_w[15] <= w_new;
                r_hh <= r_g; r_g <= r_f; r_f <= r_e; r_e <= r_d + x1;
                r_d <= r_c; r_c <= r_b; r_b <= r_a; r_a <= x1 + x2;
            end
            if (i_cmd.fold) begin
                r_h[0] <= r_h[0] + r_a; r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c; r_h[3] <= r_h[3] + r_d;
                r_h[4] <= r_h[4] + r_e; r_h[5] <= r_h[5] + r_f;
                r_h[6] <= r_h[6] + r_g; r_h[7] <= r_h[7] + r_hh;
            end
        end
    end

    assign o_status.fill       = r_fill;
    assign o_status.round_cnt  = r_rnd;
    assign o_status.round_last = (r_rnd == 7'd79);
    assign o_total_bits        = {r_total[60:0], 3'b000};
    assign o_chain_word        = r_h[i_word_sel];
endmodule

>>> rtl/sha512_ctrl.sv
module sha512_ctrl
    import sha512_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    sha512_in_if.sink   in_ch,
    sha512_out_if.source out_ch,
    input  t_status     i_status,
    input  logic [63:0] i_total_bits,
    input  logic [63:0] i_chain_word,
    output t_cmd        o_cmd,
    output logic [2:0]  o_word_sel
);
    t_state      r_state, n_state;
    logic        r_fin, n_fin;
    logic        r_padded, n_padded;
    logic [2:0]  r_widx, n_widx;
    logic [63:0] r_bits, n_bits;
    logic        acc;
    // the block now being padded is the one that carries the length
    logic        r_bits_done;

    assign acc = in_ch.valid && in_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fin    <= 1'b0;
            r_padded <= 1'b0;
            r_widx   <= '0;
        end else begin
            r_state  <= n_state;
            r_fin    <= n_fin;
            r_padded <= n_padded;
            r_widx   <= n_widx;
        end
        r_bits <= n_bits;
    end

    // does the byte written now complete the block (fill at 127)?
    logic full_next;
    assign full_next = (i_status.fill == 7'd127);

    always_comb begin
        n_state  = r_state;
        n_fin    = r_fin;
        n_padded = r_padded;
        n_widx   = r_widx;
        n_bits   = r_bits;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_fin    = in_ch.finish;
                    n_padded = 1'b0;
                    n_bits   = {i_total_bits[63:3] + {60'd0, in_ch.byte_valid}, 3'b000};
                    if (in_ch.byte_valid && full_next) n_state = S_ROUND;
                    else if (in_ch.finish)             n_state = S_PAD;
                end
            end
            S_PAD: begin
                if (!r_padded) n_padded = 1'b1;
                if (full_next) n_state = S_ROUND;
            end
            S_ROUND: if (i_status.round_last) n_state = S_FOLD;
            S_FOLD: begin
                if (!r_fin)                        n_state = S_IDLE;
                else if (r_padded && r_bits_done)  n_state = S_EMIT;
                else                               n_state = S_PAD;
            end
            S_EMIT: begin
                if (out_ch.ready) begin
                    n_widx = r_widx + 3'd1;
                    if (r_widx == 3'd7) begin
                        n_state = S_IDLE;
                        n_fin   = 1'b0;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // set when 0x80 lands before offset 112, or when a padded block that had no room ends
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_bits_done <= 1'b0;
        else if (r_state == S_IDLE) r_bits_done <= 1'b0;
        else if (r_state == S_PAD && !r_padded && i_status.fill < PAD_LIMIT)
            r_bits_done <= 1'b1;
        else if (r_state == S_FOLD && r_padded) r_bits_done <= 1'b1;
    end

    logic [7:0] pad_byte;
    logic [2:0] len_sel;
    always_comb begin
        len_sel = i_status.fill[2:0];
        if (!r_padded) pad_byte = PAD_BYTE;
        else if (r_bits_done && i_status.fill >= PAD_LIMIT + 7'd8)
            pad_byte = r_bits[8*(7-len_sel) +: 8];
        else pad_byte = 8'h00;
    end

    always_comb begin
        o_cmd       = '0;
        in_ch.ready = 1'b0;
        out_ch.valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                in_ch.ready     = 1'b1;
                o_cmd.wr_byte   = acc && in_ch.byte_valid;
                o_cmd.add_total = acc && in_ch.byte_valid;
                o_cmd.wr_data   = in_ch.data_byte;
                o_cmd.start_blk = acc && in_ch.byte_valid && full_next;
            end
            S_PAD: begin
                o_cmd.wr_byte   = 1'b1;
                o_cmd.wr_data   = pad_byte;
                o_cmd.start_blk = full_next;
            end
            S_ROUND: o_cmd.round = 1'b1;
            S_FOLD:  o_cmd.fold  = 1'b1;
            S_EMIT: begin
                out_ch.valid = 1'b1;
                o_cmd.clear  = out_ch.ready && (r_widx == 3'd7);
            end
            default: ;
        endcase
    end

    assign o_word_sel         = r_widx;
    assign out_ch.digest_word = i_chain_word;
    assign out_ch.word_index  = r_widx;
    assign out_ch.last_word   = (r_widx == 3'd7);
endmodule

>>> rtl/sha512_stream_hash.sv
// SHA-512 stream hash.
// Input channel i_in: one message byte per transfer (byte_valid), finish ends
// the message; a finish transfer may carry a last byte or none.
// Output channel o_out: eight 64-bit digest words, index 0 first, last_word
// set on index 7.
// Bytes are taken one per cycle while a block fills. The 128th byte of a
// block starts the shared round unit: 80 rounds and then a fold, during
// which input is held off.
// On finish, padding and the length are written one byte a cycle into the
// buffer (up to 128 bytes plus the compression per padded block), then the
// digest words are offered one per cycle.
// When the receiver stalls, the current word holds until taken; no input is
// taken until all eight words are gone, after which the state returns to the
// initial hash value.
// Reset (synchronous, active low) restores the initial hash value and
// empties the buffer; no clearing pass is needed.
`include "sha512_stream_hash_defines.svh"
module sha512_stream_hash
    import sha512_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    sha512_in_if.sink     i_in,
    sha512_out_if.source  o_out
);
    t_cmd        cmd;
    t_status     status;
    logic [63:0] total_bits, chain_word;
    logic [2:0]  word_sel;

    sha512_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .in_ch(i_in), .out_ch(o_out),
        .i_status(status), .i_total_bits(total_bits), .i_chain_word(chain_word),
        .o_cmd(cmd), .o_word_sel(word_sel)
    );

    sha512_datapath u_dp (
        .i_clk, .i_rst_n,
        .i_cmd(cmd), .i_word_sel(word_sel),
        .o_status(status), .o_total_bits(total_bits), .o_chain_word(chain_word)
    );

    `SHA_ASSERT_IMPL(a_no_in_while_out, i_clk, i_rst_n, o_out.valid, !i_in.ready)
    `SHA_ASSERT_IMPL(a_round_excl, i_clk, i_rst_n, cmd.round, !cmd.wr_byte && !i_in.ready)
    `SHA_ASSERT_NEXT(a_clear_empty, i_clk, i_rst_n, cmd.clear, status.fill == 7'd0)
endmodule

>>> tb/sv/sha512_tb_scoreboard.sv
`timescale 1ns / 1ps

class digest_scoreboard;
    logic [63:0] chain [8];
    logic [7:0]  blk [128];
    int unsigned fill;
    logic [63:0] total;
    logic [63:0] want_word [$];
    logic [2:0]  want_index [$];
    logic        want_last [$];
    int unsigned errors;

    function new();
        errors = 0;
        clear_state();
    endfunction

    function void clear_state();
        chain = sha512_pkg::IV;
        fill  = 0;
        total = '0;
    endfunction

    function logic [63:0] rotr(logic [63:0] v, int n);
        return (v >> n) | (v << (64 - n));
    endfunction

    function void compress();
        logic [63:0] w [80];
        logic [63:0] a, b, c, d, e, f, g, h, x1, x2, s0, s1;
        for (int t = 0; t < 16; t++) begin
            w[t] = '0;
            for (int j = 0; j < 8; j++) w[t] = (w[t] << 8) | 64'(blk[t*8+j]);
        end
        for (int t = 16; t < 80; t++) begin
            s0 = rotr(w[t-15], 1) ^ rotr(w[t-15], 8) ^ (w[t-15] >> 7);
            s1 = rotr(w[t-2], 19) ^ rotr(w[t-2], 61) ^ (w[t-2] >> 6);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
        end
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
        for (int t = 0; t < 80; t++) begin
            x1 = h + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41)) + ((e & f) ^ (~e & g))
                 + sha512_pkg::round_k(7'(t)) + w[t];
            x2 = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + x1;
            d = c; c = b; b = a; a = x1 + x2;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
        chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endfunction

    function void append(logic [7:0] v);
        blk[fill] = v;
        fill = (fill + 1) % 128;
        if (fill == 0) compress();
    endfunction

    function void note_transfer(logic [7:0] data, logic has_byte, logic fin);
        logic [63:0] bits;
        if (has_byte) begin
            append(data);
            total += 1;
        end
        if (!fin) return;
        bits = total << 3;
        append(8'h80);
        while (fill != 112) append(8'h00);
        for (int k = 0; k < 8; k++) append(8'h00);
        for (int k = 0; k < 8; k++) append(bits[(7-k)*8 +: 8]);
        for (int k = 0; k < 8; k++) begin
            want_word.push_back(chain[k]);
            want_index.push_back(3'(k));
            want_last.push_back(k == 7);
        end
        clear_state();
    endfunction

    function void check_word(logic [63:0] word, logic [2:0] idx, logic last);
        logic [63:0] ew;
        logic [2:0]  ei;
        logic        el;
        if (want_word.size() == 0) begin
            errors++;
            $display("%0t: unexpected digest word %h", $time, word);
            return;
        end
        ew = want_word.pop_front();
        ei = want_index.pop_front();
        el = want_last.pop_front();
        if (word !== ew) begin
            errors++;
            $display("%0t: digest_word exp %h got %h", $time, ew, word);
        end
        if (idx !== ei) begin
            errors++;
            $display("%0t: word_index exp %0d got %0d", $time, ei, idx);
        end
        if (last !== el) begin
            errors++;
            $display("%0t: last_word exp %0b got %0b", $time, el, last);
        end
    endfunction

    function int unsigned pending();
        return want_word.size();
    endfunction
endclass

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import sha512_pkg::*;

    logic i_clk;
    logic i_rst_n;
    sha512_in_if  byte_ch ();
    sha512_out_if digest_ch ();

    sha512_stream_hash i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch.sink),
        .o_out   (digest_ch.source)
    );

    digest_scoreboard sb = new();
    int unsigned quiet_cycles;
    bit          calm;
    bit          long_hold;
    bit          done;

    always begin
        i_clk = 1'b0; #2;
        i_clk = 1'b1; #2;
    end

    // accepted transfers and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (byte_ch.valid && byte_ch.ready)
                sb.note_transfer(byte_ch.data_byte, byte_ch.byte_valid, byte_ch.finish);
            if (digest_ch.valid && digest_ch.ready)
                sb.check_word(digest_ch.digest_word, digest_ch.word_index,
                    digest_ch.last_word);
            if ((byte_ch.valid && byte_ch.ready) || (digest_ch.valid && digest_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > 20000) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // receiver with random stall bursts
    initial begin
        digest_ch.ready = 1'b0;
        @(posedge i_rst_n);
        while (!done) begin
            @(negedge i_clk);
            if (long_hold) begin
                digest_ch.ready <= 1'b0;
                repeat (400) @(negedge i_clk);
                long_hold = 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                digest_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 19) - 1) @(negedge i_clk);
            end else begin
                digest_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send(logic [7:0] d, logic bv, logic fin);
        if (!calm && $urandom_range(0, 7) == 0) begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        byte_ch.valid      <= 1'b1;
        byte_ch.data_byte  <= d;
        byte_ch.byte_valid <= bv;
        byte_ch.finish     <= fin;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        byte_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    task automatic send_message(int unsigned n, bit fin_has_byte);
        for (int i = 0; i < n; i++) send(8'($urandom), 1'b1, 1'b0);
        send(8'($urandom), fin_has_byte, 1'b1);
    endtask

    initial begin
        int unsigned len;
        byte_ch.valid      = 1'b0;
        byte_ch.data_byte  = '0;
        byte_ch.byte_valid = 1'b0;
        byte_ch.finish     = 1'b0;
        calm = 1'b0;
        long_hold = 1'b0;
        done = 1'b0;
        quiet_cycles = 0;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty message, extremes, empty items, finish with byte
        send(8'h00, 1'b0, 1'b1);
        send(8'h00, 1'b1, 1'b0);
        send(8'hFF, 1'b1, 1'b0);
        send(8'hA5, 1'b0, 1'b0);
        send(8'h5A, 1'b1, 1'b1);
        send(8'hFF, 1'b1, 1'b1);
        drain();
        // padding marker at offset 112 pushes the length into a second block
        send_message(112, 1'b0);
        drain();

        // long receiver hold-off while bytes keep coming
        long_hold = 1'b1;
        for (int m = 0; m < 3; m++) send_message($urandom_range(0, 3), 1'b1);
        drain();

        for (int m = 0; m < 4; m++) begin
            if (m == 3) calm = 1'b1;
            len = $urandom_range(0, 4);
            for (int i = 0; i < len; i++)
                send(8'($urandom), ($urandom_range(0, 9) != 0), 1'b0);
            send(8'($urandom), 1'($urandom), 1'b1);
        end
        byte_ch.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        done = 1'b1;
        if (sb.errors == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
